@@ rtl/bba_pkg.sv @@
// Shared types, codes and defaults of the bitmap block allocator.
package bba_pkg;

	// Width of block numbers, counts and the size register.
	localparam int unsigned FIELD_W = 16;

	// Defaults for the top-level parameters.
	localparam int unsigned DEF_MAX_BLOCKS = 32768;
	localparam int unsigned DEF_WORD_BITS  = 64;

	// Size register value after reset.
	localparam logic [FIELD_W-1:0] TOTAL_RESET = 16'd32768;

	// Command codes.
	localparam logic [1:0] CMD_ALLOC_LOW  = 2'd0;
	localparam logic [1:0] CMD_ALLOC_HIGH = 2'd1;
	localparam logic [1:0] CMD_FREE       = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// One command beat.
	typedef struct packed {
		logic [1:0]         command;
		logic [FIELD_W-1:0] block_number;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] allocated_block;
		logic [FIELD_W-1:0] free_count;
	} out_beat_t;

endpackage

@@ rtl/bitmap_block_allocator.sv @@
// Top level of the bitmap block allocator: command sequencer around the bitmap memory.
//
//  Channel   Signals                     Moves
//  command   in_valid, in_ready, in_data one allocate or free command per beat
//  result    out_valid, out_ready,       one status, block number and free count
//            out_data                    per command beat
//  config    cfg_we, cfg_wdata           size register write, no wait
//
// An allocate passes S_DIV1, S_DIV2 and S_PREP, then scans in S_SCAN; the scan reads one word
// a cycle from the single memory read port. A free passes the same states to S_FREE instead;
// a rejected command goes straight to S_RESP. After reset a clearing pass writes zeros to all
// MAP_WORDS words, one a cycle, and no command is taken until it ends.
// A finished result waits in the output register; the next command is taken meanwhile
// and its own result holds until the output register is free.
module bitmap_block_allocator #(
	parameter int unsigned MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
	parameter int unsigned WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bba_pkg::in_beat_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bba_pkg::out_beat_t          out_data,
	input  logic                        cfg_we,
	input  logic [bba_pkg::FIELD_W-1:0] cfg_wdata
);
	import bba_pkg::*;

	localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned BIDX_W    = $clog2(WORD_BITS);
	localparam int unsigned FW        = FIELD_W;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_PREP, S_SCAN, S_FREE, S_RESP
	} state_t;

	state_t state_q;

	logic [FW-1:0]        tot_q;
	logic [FW-1:0]        cnt_q;
	logic [WIDX_W-1:0]    clr_q;
	logic [1:0]           cmd_q;
	logic [FW-1:0]        size_q;
	logic [FW-1:0]        start_q;
	logic [FW-1:0]        dx_q;
	logic [FW-1:0]        start_w_q;
	logic [BIDX_W-1:0]    start_b_q;
	logic [FW-1:0]        end_w_q;
	logic [BIDX_W-1:0]    end_b_q;
	logic [FW-1:0]        last_w_q;
	logic [FW-1:0]        w_q;
	logic [FW-1:0]        base_q;
	logic                 rv_s1;
	logic [FW-1:0]        rw_s1;
	logic [FW-1:0]        rbase_s1;
	logic [1:0]           res_status_q;
	logic [FW-1:0]        res_block_q;
	logic                 out_valid_q;
	out_beat_t            out_q;

	logic [FW-1:0]        size_c;
	logic [FW-1:0]        start_c;
	logic [FW-1:0]        num_m1;
	logic [FW-1:0]        qa;
	logic [BIDX_W-1:0]    ra;
	logic [FW-1:0]        qb;
	logic [BIDX_W-1:0]    rb;
	logic [FW-1:0]        free_c;

	logic                 mem_we;
	logic [WIDX_W-1:0]    mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [WIDX_W-1:0]    mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	logic [WORD_BITS-1:0] avail;
	logic [BIDX_W-1:0]    lo_b;
	logic                 hi_en;
	logic                 ffz_found;
	logic [WORD_BITS-1:0] ffz_onehot;
	logic [BIDX_W-1:0]    ffz_idx;
	logic [WORD_BITS-1:0] free_bit;
	logic                 scan_last;

	// Effective size and command derived values.
	assign size_c  = (32'(tot_q) > 32'(MAX_BLOCKS)) ? FW'(MAX_BLOCKS) : tot_q;
	assign start_c = (in_data.command == CMD_ALLOC_HIGH) ? (size_c >> 1) : '0;
	assign num_m1  = in_data.block_number - FW'(1);
	assign free_c  = (size_q > cnt_q) ? (size_q - cnt_q) : '0;

	// Word and bit position of the search start or freed block, and of the size bound.
	bba_wdiv #(.WORD_BITS(WORD_BITS)) u_div_start (
		.clk (clk),
		.num (dx_q),
		.quo (qa),
		.rem (ra)
	);

	bba_wdiv #(.WORD_BITS(WORD_BITS)) u_div_end (
		.clk (clk),
		.num (size_q),
		.quo (qb),
		.rem (rb)
	);

	// Bitmap memory.
	bba_map_ram #(.DEPTH(MAP_WORDS), .WIDTH(WORD_BITS)) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Bits of the returning word that lie inside the search range.
	assign lo_b  = (rw_s1 == start_w_q) ? start_b_q : '0;
	assign hi_en = (rw_s1 == end_w_q);
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			avail[b] = (BIDX_W'(b) >= lo_b) && (!hi_en || (BIDX_W'(b) < end_b_q));
		end
	end

	bba_ffz #(.WORD_BITS(WORD_BITS)) u_ffz (
		.used   (mem_rdata | ~avail),
		.found  (ffz_found),
		.onehot (ffz_onehot),
		.idx    (ffz_idx)
	);

	assign free_bit  = WORD_BITS'(1) << start_b_q;
	assign scan_last = (rw_s1 == last_w_q);

	// Memory port selection.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = WIDX_W'(w_q);
		mem_we    = 1'b0;
		mem_waddr = WIDX_W'(rw_s1);
		mem_wdata = mem_rdata | ffz_onehot;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_PREP: begin
				mem_re    = (cmd_q == CMD_FREE);
				mem_raddr = WIDX_W'(qa);
			end
			S_SCAN: begin
				mem_re = (w_q <= last_w_q);
				mem_we = rv_s1 && ffz_found;
			end
			S_FREE: begin
				mem_waddr = WIDX_W'(start_w_q);
				mem_wdata = mem_rdata & ~free_bit;
				mem_we    = mem_rdata[start_b_q];
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// Size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= TOTAL_RESET;
		end else if (cfg_we) begin
			tot_q <= cfg_wdata;
		end
	end

	// Command sequencer with its registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A taken result leaves unless a new one is loaded in the same cycle.
			if (out_valid_q && out_ready && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WIDX_W'(1);
					if (clr_q == WIDX_W'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q        <= in_data.command;
						size_q       <= size_c;
						start_q      <= start_c;
						dx_q         <= (in_data.command == CMD_FREE) ? num_m1 : start_c;
						res_status_q <= ST_OK;
						res_block_q  <= '0;
						state_q      <= S_DIV1;
						case (in_data.command)
							CMD_ALLOC_LOW, CMD_ALLOC_HIGH: begin
								if (size_c == '0) begin
									res_status_q <= ST_FULL;
									state_q      <= S_RESP;
								end
							end
							CMD_FREE: begin
								if ((in_data.block_number == '0) ||
								    (in_data.block_number > size_c)) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_RESP;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_DIV1: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					start_w_q <= qa;
					start_b_q <= ra;
					end_w_q   <= qb;
					end_b_q   <= rb;
					last_w_q  <= (rb != '0) ? qb : (qb - FW'(1));
					w_q       <= qa;
					base_q    <= start_q - FW'(ra);
					rv_s1     <= 1'b0;
					state_q   <= (cmd_q == CMD_FREE) ? S_FREE : S_SCAN;
				end
				S_SCAN: begin
					// Check the word read last cycle while the next read is issued.
					if (rv_s1 && ffz_found) begin
						cnt_q       <= cnt_q + FW'(1);
						res_block_q <= rbase_s1 + FW'(ffz_idx) + FW'(1);
						rv_s1       <= 1'b0;
						state_q     <= S_RESP;
					end else if (rv_s1 && scan_last) begin
						res_status_q <= ST_FULL;
						rv_s1        <= 1'b0;
						state_q      <= S_RESP;
					end else if (w_q <= last_w_q) begin
						rv_s1    <= 1'b1;
						rw_s1    <= w_q;
						rbase_s1 <= base_q;
						w_q      <= w_q + FW'(1);
						base_q   <= base_q + FW'(WORD_BITS);
					end else begin
						rv_s1 <= 1'b0;
					end
				end
				S_FREE: begin
					if (mem_rdata[start_b_q] && (cnt_q != '0)) begin
						cnt_q <= cnt_q - FW'(1);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_q.status          <= res_status_q;
						out_q.allocated_block <= res_block_q;
						out_q.free_count      <= free_c;
						out_valid_q           <= 1'b1;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// No command is taken while the clearing pass runs.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("command accepted during clearing pass");

	// The allocated count moves by at most one block per cycle.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 16'd1) ||
		(cnt_q == $past(cnt_q) - 16'd1))
		else $error("allocated count jumped");

	// A scan write-back only touches a word inside the search range.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q == S_SCAN)) |-> (rv_s1 && (rw_s1 <= last_w_q) &&
		(rw_s1 >= start_w_q)))
		else $error("scan write outside the search range");

endmodule

@@ rtl/bba_wdiv.sv @@
// Two-stage divider of a block number by the constant word width.
module bba_wdiv #(
	parameter int unsigned WORD_BITS = bba_pkg::DEF_WORD_BITS
) (
	input  logic                                  clk,
	input  logic [bba_pkg::FIELD_W-1:0]           num,
	output logic [bba_pkg::FIELD_W-1:0]           quo,
	output logic [$clog2(WORD_BITS)-1:0]          rem
);
	import bba_pkg::*;

	localparam int unsigned BIDX_W = $clog2(WORD_BITS);
	localparam int unsigned SH     = FIELD_W + BIDX_W;
	localparam int unsigned RW     = FIELD_W + 1;
	localparam int unsigned PW     = FIELD_W + RW;
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << SH) / WORD_BITS);

	logic [FIELD_W-1:0] num_s1;
	logic [PW-1:0]      prod_s1;
	logic [FIELD_W-1:0] q0;
	logic [FIELD_W-1:0] back;
	logic [FIELD_W-1:0] r0;

	// Stage one: multiply by the truncated reciprocal.
	always_ff @(posedge clk) begin
		num_s1  <= num;
		prod_s1 <= PW'(num) * PW'(RECIP);
	end

	// The estimate is low by at most one; one compare and subtract corrects it.
	assign q0   = FIELD_W'(prod_s1 >> SH);
	assign back = FIELD_W'(q0 * FIELD_W'(WORD_BITS));
	assign r0   = num_s1 - back;

	// Stage two: corrected quotient and remainder.
	always_ff @(posedge clk) begin
		if (r0 >= FIELD_W'(WORD_BITS)) begin
			quo <= q0 + FIELD_W'(1);
			rem <= BIDX_W'(r0 - FIELD_W'(WORD_BITS));
		end else begin
			quo <= q0;
			rem <= BIDX_W'(r0);
		end
	end

endmodule

@@ rtl/bba_map_ram.sv @@
// Usage bitmap storage: one write port, one read port with registered data.
module bba_map_ram #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned WIDTH = bba_pkg::DEF_WORD_BITS
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	import bba_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered output data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/bba_ffz.sv @@
// Finds the lowest clear bit of a bitmap word.
module bba_ffz #(
	parameter int unsigned WORD_BITS = bba_pkg::DEF_WORD_BITS
) (
	input  logic [WORD_BITS-1:0]         used,
	output logic                         found,
	output logic [WORD_BITS-1:0]         onehot,
	output logic [$clog2(WORD_BITS)-1:0] idx
);
	import bba_pkg::*;

	localparam int unsigned BIDX_W = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] clr;

	// Isolate the lowest set bit of the inverted word with one add.
	assign clr    = ~used;
	assign onehot = clr & (~clr + WORD_BITS'(1));
	assign found  = |clr;

	// Encode the one-hot position.
	always_comb begin
		idx = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (onehot[b]) begin
				idx = idx | BIDX_W'(b);
			end
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the bitmap block allocator: directed and random command traffic.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	localparam int unsigned MAX_BLOCKS = DEF_MAX_BLOCKS;
	localparam int unsigned WORD_BITS  = DEF_WORD_BITS;
	localparam int unsigned MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;

	// The one command code the block leaves unused.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Settle time after the last result before a size write or the end of the run.
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned TAIL_CYCLES   = 600;

	typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	in_beat_t           in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_beat_t          out_data;
	logic               cfg_we    = 1'b0;
	logic [FIELD_W-1:0] cfg_wdata = '0;

	// Shadow copy of the allocator state.
	bit [WORD_BITS-1:0] usage_words [MAP_WORDS];
	logic [FIELD_W-1:0] used_blocks = '0;
	logic [FIELD_W-1:0] block_total = TOTAL_RESET;
	int unsigned        held_blocks [$];

	out_beat_t          results_owed [$];
	int unsigned        fault_count = 0;

	// Sender pacing.
	int unsigned        burst_left = 0;
	bit                 steady_sender = 1'b0;

	// Receiver stall pattern.
	rx_mode_t           rx_mode = RX_OPEN;
	int unsigned        rx_left = 0;
	logic [7:0]         rx_pattern = 8'hff;
	logic [2:0]         rx_phase = '0;

	bitmap_block_allocator #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.WORD_BITS (WORD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Number of blocks actually tracked under the current size register.
	function automatic int unsigned tracked_blocks();
		return (block_total > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_total);
	endfunction

	// Lowest clear bit in [from, upto), skipping full words; upto if none.
	function automatic int unsigned lowest_clear_bit(input int unsigned from,
			input int unsigned upto);
		int unsigned n;
		n = from;
		while (n < upto) begin
			if (usage_words[n / WORD_BITS] == '1) begin
				n = (n / WORD_BITS + 1) * WORD_BITS;
			end else if (!usage_words[n / WORD_BITS][n % WORD_BITS]) begin
				return n;
			end else begin
				n++;
			end
		end
		return upto;
	endfunction

	// Apply one command to the shadow state and return the result it must produce.
	function automatic out_beat_t predict_outcome(input in_beat_t cmd);
		out_beat_t   res;
		int unsigned size;
		int unsigned n;
		int unsigned num;
		size = tracked_blocks();
		num  = cmd.block_number;
		res  = '0;
		res.status = ST_OK;
		case (cmd.command)
			CMD_ALLOC_LOW, CMD_ALLOC_HIGH: begin
				n = lowest_clear_bit((cmd.command == CMD_ALLOC_HIGH) ? size / 2 : 0, size);
				if (n < size) begin
					usage_words[n / WORD_BITS][n % WORD_BITS] = 1'b1;
					used_blocks = used_blocks + 1'b1;
					res.allocated_block = FIELD_W'(n + 1);
					held_blocks.push_back(n + 1);
				end else begin
					res.status = ST_FULL;
				end
			end
			CMD_FREE: begin
				if (num == 0 || num > size) begin
					res.status = ST_RANGE;
				end else if (usage_words[(num - 1) / WORD_BITS][(num - 1) % WORD_BITS]) begin
					usage_words[(num - 1) / WORD_BITS][(num - 1) % WORD_BITS] = 1'b0;
					if (used_blocks != 0) used_blocks = used_blocks - 1'b1;
					foreach (held_blocks[i]) begin
						if (held_blocks[i] == num) begin
							held_blocks.delete(i);
							break;
						end
					end
				end
			end
			default: ;
		endcase
		res.free_count = (size > used_blocks) ? FIELD_W'(size - used_blocks) : '0;
		return res;
	endfunction

	// Once the current burst is used up, insert a random gap unless the sender is steady.
	task automatic pace_sender();
		if (burst_left == 0) begin
			if (!steady_sender) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	// Present one command beat and hold it until the block takes it.
	task automatic issue_command(input logic [1:0] command, input logic [FIELD_W-1:0] number);
		in_beat_t beat;
		beat.command      = command;
		beat.block_number = number;
		pace_sender();
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
		results_owed.push_back(predict_outcome(beat));
	endtask

	// Stop sending and wait until every owed result has been taken.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (results_owed.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the size register with the block idle.
	task automatic set_block_total(input logic [FIELD_W-1:0] value);
		wait_all_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		block_total = value;
	endtask

	// Compare one result beat against the oldest owed result.
	task automatic check_result_beat(input out_beat_t got);
		out_beat_t want;
		if (results_owed.size() == 0) begin
			$error("unexpected result beat: status %0d block %0d free %0d",
				got.status, got.allocated_block, got.free_count);
			fault_count++;
		end else begin
			want = results_owed.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fault_count++;
			end
			if (got.allocated_block !== want.allocated_block) begin
				$error("allocated_block: expected %0d, got %0d",
					want.allocated_block, got.allocated_block);
				fault_count++;
			end
			if (got.free_count !== want.free_count) begin
				$error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
				fault_count++;
			end
		end
	endtask

	// Result side: check each accepted beat, then pick the next ready value.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) check_result_beat(out_data);
		if (rx_left == 0) begin
			rx_mode    = rx_mode_t'($urandom_range(0, 3));
			rx_pattern = 8'($urandom) | 8'h01;
			rx_left    = $urandom_range(40, 300);
		end else begin
			rx_left--;
		end
		rx_phase = rx_phase + 1'b1;
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= rx_pattern[rx_phase];
		endcase
	end

	// Reset size: both allocate forms, frees in and out of range, the unused command.
	task automatic test_power_on_size();
		issue_command(CMD_ALLOC_LOW, 16'hffff);
		issue_command(CMD_ALLOC_HIGH, 16'h0000);
		issue_command(CMD_FREE, 16'd16385);
		issue_command(CMD_FREE, 16'd1);
		issue_command(CMD_FREE, 16'd1);
		issue_command(CMD_FREE, 16'd0);
		issue_command(CMD_FREE, 16'd32769);
		issue_command(CMD_FREE, 16'hffff);
		issue_command(CMD_FREE, 16'd32768);
		issue_command(CMD_UNUSED, 16'hffff);
	endtask

	// A size of zero tracks nothing.
	task automatic test_zero_size();
		set_block_total(16'd0);
		issue_command(CMD_ALLOC_LOW, 16'd0);
		issue_command(CMD_ALLOC_HIGH, 16'd0);
		issue_command(CMD_FREE, 16'd1);
	endtask

	// A size above the bitmap capacity acts as the capacity.
	task automatic test_oversized_size();
		set_block_total(16'hffff);
		issue_command(CMD_ALLOC_HIGH, 16'd0);
		issue_command(CMD_FREE, 16'd16385);
		issue_command(CMD_FREE, 16'd32769);
	endtask

	// Fill a small map, shrink it under the held blocks, then grow it back.
	task automatic test_shrunk_size();
		set_block_total(16'd5);
		issue_command(CMD_ALLOC_HIGH, 16'd0);
		repeat (5) issue_command(CMD_ALLOC_LOW, 16'd0);
		set_block_total(16'd2);
		issue_command(CMD_FREE, 16'd3);
		issue_command(CMD_ALLOC_HIGH, 16'd0);
		set_block_total(16'd5);
		issue_command(CMD_FREE, 16'd3);
	endtask

	// One stretch of random traffic under a fixed size.
	task automatic run_random_phase(input logic [FIELD_W-1:0] size, input int unsigned count,
			input bit steady);
		int unsigned pick;
		int unsigned limit;
		set_block_total(size);
		steady_sender = steady;
		limit = tracked_blocks();
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				issue_command(CMD_ALLOC_LOW, FIELD_W'($urandom));
			end else if (pick < 52) begin
				issue_command(CMD_ALLOC_HIGH, FIELD_W'($urandom));
			end else if (pick < 84 && held_blocks.size() != 0) begin
				issue_command(CMD_FREE,
					FIELD_W'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]));
			end else if (pick < 93) begin
				issue_command(CMD_FREE, FIELD_W'($urandom_range(0, limit + 2)));
			end else if (pick < 97) begin
				issue_command(CMD_FREE, FIELD_W'($urandom));
			end else begin
				issue_command(CMD_UNUSED, FIELD_W'($urandom));
			end
			// Now and then let the block run dry in mid-phase.
			if ($urandom_range(0, 199) == 0) wait_all_results();
		end
		steady_sender = 1'b0;
	endtask

	// Random traffic over small, boundary and oversized maps.
	task automatic test_random_traffic();
		logic [FIELD_W-1:0] size;
		for (int p = 0; p < 14; p++) begin
			case (p)
				0:       size = 16'd1;
				1:       size = 16'd64;
				2:       size = 16'd32768;
				3:       size = 16'hffff;
				4:       size = 16'd0;
				5:       size = FIELD_W'($urandom);
				6:       size = 16'd128;
				default: size = FIELD_W'($urandom_range(2, 130));
			endcase
			run_random_phase(size, (p == 4) ? 20 : 105, (p % 4) == 1);
		end
	endtask

	// Main sequence.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_size();
		test_zero_size();
		test_oversized_size();
		test_shrunk_size();
		test_random_traffic();
		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(64'd40_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ bitmap_block_allocator.f @@
rtl/bba_pkg.sv
rtl/bba_wdiv.sv
rtl/bba_map_ram.sv
rtl/bba_ffz.sv
rtl/bitmap_block_allocator.sv
tb/tb_top.sv
